FILE: hw/rtl/kwm_pkg.sv
`default_nettype none
// kwm_pkg: sizes, item types, op and status codes and state type of the k-way merge engine
// no dependencies; used by kwm_store, kwm_min_unit and k_way_sorted_merge
package kwm_pkg;

	localparam int NUM_LISTS   = 16;
	localparam int LIST_DEPTH  = 64;
	localparam int VALUE_WIDTH = 32;

	localparam int IDX_W  = $clog2(NUM_LISTS);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef logic signed [VALUE_WIDTH-1:0] elem_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         list_index;
		logic signed [31:0] value;
	} kwm_in_t;

	typedef struct packed {
		logic signed [31:0] merged_value;
		logic [3:0]         source_list;
		logic [1:0]         status;
	} kwm_out_t;

	// candidate head presented to the compare unit
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} kwm_cand_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} kwm_best_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_FINISH,
		S_DONE
	} state_t;

	function automatic elem_t fit_in(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic signed [31:0] fit_out(input elem_t v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/kwm_store.sv
`default_nettype none
// kwm_store: element memory of all lists, one write port and one registered read port
// depends on kwm_pkg
module kwm_store (
	input  wire                    clk,
	input  wire                    we,
	input  wire [kwm_pkg::ADDR_W-1:0] waddr,
	input  kwm_pkg::elem_t         wdata,
	input  wire                    re,
	input  wire [kwm_pkg::ADDR_W-1:0] raddr,
	output kwm_pkg::elem_t         rdata
);
	import kwm_pkg::*;

	elem_t mem_q [STORE_DEPTH];
	elem_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/kwm_min_unit.sv
`default_nettype none
// kwm_min_unit: shared signed compare, keeps the smallest head seen during a scan
// depends on kwm_pkg
module kwm_min_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  kwm_pkg::kwm_cand_t cand,
	input  kwm_pkg::elem_t     cand_val,
	output kwm_pkg::kwm_best_t best,
	output kwm_pkg::elem_t     best_val
);
	import kwm_pkg::*;

	kwm_best_t best_q;
	elem_t     best_val_q;
	logic      take;

	// strict less keeps the lowest list on ties, lists arrive in ascending order
	assign take = cand.valid && (!best_q.found || (cand_val < best_val_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (start) begin
			best_q <= '0;
		end else if (take) begin
			best_q.found <= 1'b1;
			best_q.idx   <= cand.idx;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !start) begin
			best_val_q <= cand_val;
		end
	end

	assign best     = best_q;
	assign best_val = best_val_q;

endmodule
`default_nettype wire

FILE: hw/rtl/k_way_sorted_merge.sv
`default_nettype none
// k_way_sorted_merge: k-way merge engine, sequencer, per-list counts and result register
// depends on kwm_pkg, kwm_store, kwm_min_unit
//
// req channel (valid/ready) carries one item: op, list_index, value.
// rsp channel (valid/ready) returns exactly one item per request:
// merged_value, source_list, status.
// load appends value to a list (status full if the list is full or the
// index is out of range), next returns the smallest head over all lists
// (ties to the lowest list, status empty when nothing is left), clear
// empties every list.
// the block takes one request at a time. load, clear and unused ops step
// through accept, execute and hand-off; next also walks the lists between
// execute and hand-off, a scan of one list head per cycle through the single
// store read port into the shared compare unit, then a drain and a finish step.
// req_ready is high only when the sequencer is idle; a finished result sits
// in the output register, so a new request is taken while the receiver
// stalls, and its result waits until the output register is free.
// reset clears all list counts and the control state at once; store
// contents need no clearing as only written entries are ever read.
module k_way_sorted_merge (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  kwm_pkg::kwm_in_t req,
	output logic             rsp_valid,
	input  wire              rsp_ready,
	output kwm_pkg::kwm_out_t rsp
);
	import kwm_pkg::*;

	localparam logic [IDX_W-1:0] LAST_LIST = IDX_W'(NUM_LISTS - 1);

	state_t state_q, state_d;

	kwm_in_t   req_q;
	kwm_out_t  res_q;
	kwm_out_t  out_q;
	logic      out_valid_q;

	logic [CNT_W-1:0] rc_q [NUM_LISTS];
	logic [CNT_W-1:0] wc_q [NUM_LISTS];
	logic [IDX_W-1:0] scan_q;

	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [IDX_W-1:0] cnt_sel;
	logic [CNT_W-1:0] rc_sel, wc_sel;
	logic             idx_ok, load_ok, head_ok;

	logic accept, exec_go, scan_go, finish_go, done_go, slot_free;

	logic [ADDR_W-1:0] waddr, raddr;
	elem_t             rdata;
	kwm_cand_t         cand;
	kwm_best_t         best;
	elem_t             best_val;

	assign slot_free = !out_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (req_valid) state_d = S_EXEC;
			S_EXEC:   state_d = (req_q.op == OP_NEXT) ? S_SCAN : S_DONE;
			S_SCAN:   if (scan_q == LAST_LIST) state_d = S_DRAIN;
			S_DRAIN:  state_d = S_FINISH;
			S_FINISH: state_d = S_DONE;
			S_DONE:   if (slot_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control decode
	always_comb begin
		req_ready = 1'b0;
		exec_go   = 1'b0;
		scan_go   = 1'b0;
		finish_go = 1'b0;
		done_go   = 1'b0;
		case (state_q)
			S_IDLE:   req_ready = 1'b1;
			S_EXEC:   exec_go   = 1'b1;
			S_SCAN:   scan_go   = 1'b1;
			S_FINISH: finish_go = 1'b1;
			S_DONE:   done_go   = slot_free;
			default:  req_ready = 1'b0;
		endcase
	end

	assign accept = req_valid && req_ready;

	// one count read address, shared by the scan and by load
	assign cnt_sel = scan_go ? scan_q : IDX_W'(req_q.list_index);
	assign rc_sel  = rc_q[cnt_sel];
	assign wc_sel  = wc_q[cnt_sel];
	assign idx_ok  = 32'(req_q.list_index) < 32'(NUM_LISTS);
	assign load_ok = idx_ok && (wc_sel < CNT_W'(LIST_DEPTH));
	assign head_ok = rc_sel < wc_sel;

	assign waddr = ADDR_W'(32'(cnt_sel) * 32'(LIST_DEPTH) + 32'(wc_sel));
	assign raddr = ADDR_W'(32'(cnt_sel) * 32'(LIST_DEPTH) + 32'(rc_sel));

	kwm_store u_store (
		.clk   (clk),
		.we    (exec_go && (req_q.op == OP_LOAD) && load_ok),
		.waddr (waddr),
		.wdata (fit_in(req_q.value)),
		.re    (scan_go && head_ok),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cand.valid = valid_s1;
	assign cand.idx   = idx_s1;

	kwm_min_unit u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (exec_go),
		.cand     (cand),
		.cand_val (rdata),
		.best     (best),
		.best_val (best_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			scan_q      <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				rc_q[i] <= '0;
				wc_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			valid_s1 <= scan_go && head_ok;
			if (exec_go) begin
				scan_q <= '0;
			end else if (scan_go) begin
				scan_q <= scan_q + 1'b1;
			end
			if (exec_go && (req_q.op == OP_LOAD) && load_ok) begin
				wc_q[cnt_sel] <= wc_sel + 1'b1;
			end
			if (exec_go && (req_q.op == OP_CLEAR)) begin
				for (int i = 0; i < NUM_LISTS; i++) begin
					rc_q[i] <= '0;
					wc_q[i] <= '0;
				end
			end
			if (finish_go && best.found) begin
				rc_q[best.idx] <= rc_q[best.idx] + 1'b1;
			end
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (scan_go) begin
			idx_s1 <= scan_q;
		end
		if (exec_go) begin
			res_q.merged_value <= '0;
			res_q.source_list  <= '0;
			res_q.status       <= ((req_q.op == OP_LOAD) && !load_ok) ? STAT_FULL : STAT_OK;
		end else if (finish_go) begin
			if (best.found) begin
				res_q.merged_value <= fit_out(best_val);
				res_q.source_list  <= 4'(best.idx);
				res_q.status       <= STAT_OK;
			end else begin
				res_q.merged_value <= '0;
				res_q.source_list  <= '0;
				res_q.status       <= STAT_EMPTY;
			end
		end
		if (done_go) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire
